// ===== hw/rtl/tspl_pkg.sv =====
// Package for the two-stage piecewise-linear map: command codes, register
// indexes and the fixed field widths of the block's ports.
// Depends on nothing; imported by two_stage_piecewise_linear_map.
`timescale 1ns / 1ps

package tspl_pkg;

    localparam int CMD_W   = 2;
    localparam int IDX_W   = 4;
    localparam int DATA_W  = 16;
    localparam int LEN_W   = 5;
    localparam int CFG_A_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_CONVERT     = 2'd0,
        CMD_WRITE_LEVEL = 2'd1,
        CMD_WRITE_DUTY  = 2'd2,
        CMD_NONE        = 2'd3
    } t_command;

    typedef enum logic [CFG_A_W-1:0] {
        REG_LEVEL_LEN = 2'd0,
        REG_DUTY_LEN  = 2'd1,
        REG_MAX_DUTY  = 2'd2,
        REG_UNUSED    = 2'd3
    } t_cfg_reg;

    localparam logic [DATA_W-1:0] MAX_DUTY_RESET = 16'd255;

endpackage

// ===== hw/rtl/two_stage_piecewise_linear_map.sv =====
// Top level of the two-stage piecewise-linear backlight map: the two table
// memories, the walk sequencer, the multiplier and the serial divider.
// Depends on tspl_pkg.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake                 Payload
//  input     in         i_in_valid / o_in_stall   command, entry_index, entry_key,
//                                                 entry_value, level
//  output    out        o_out_valid / i_out_stall duty, table_error
//  config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// A table write returns no transaction. A conversion walks each table entry by
// entry, reading each entry from the synchronous memory and then comparing it,
// and, where it interpolates, passes through the multiplier, the restoring
// divider and the final add. The longest conversion interpolates at the last
// entry of both tables; the two table walks make up most of its length, which
// grows with TABLE_DEPTH.
// Reset is synchronous and active low; the tables are not cleared and hold
// nothing meaningful until written. A stalled result waits in the output
// register without blocking the input; a following conversion holds in its last
// state until the register is free.

module two_stage_piecewise_linear_map #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [tspl_pkg::CMD_W-1:0]    i_command,
    input  logic [tspl_pkg::IDX_W-1:0]    i_entry_index,
    input  logic [tspl_pkg::DATA_W-1:0]   i_entry_key,
    input  logic [tspl_pkg::DATA_W-1:0]   i_entry_value,
    input  logic [tspl_pkg::DATA_W-1:0]   i_level,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tspl_pkg::DATA_W-1:0]   o_duty,
    output logic                          o_table_error,
    // configuration port
    input  logic                          i_cfg_we,
    input  logic [tspl_pkg::CFG_A_W-1:0]  i_cfg_index,
    input  logic [tspl_pkg::DATA_W-1:0]   i_cfg_data
);

    import tspl_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int LW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = 2 * DATA_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WAIT,
        S_CMP,
        S_MUL,
        S_DIV,
        S_ADD,
        S_OUT
    } t_state;

    // Each memory word holds one table entry: key in the upper half, value in
    // the lower half.
    logic [EW-1:0] level_mem [TABLE_DEPTH];
    logic [EW-1:0] duty_mem  [TABLE_DEPTH];
    logic [EW-1:0] r_level_rd;
    logic [EW-1:0] r_duty_rd;

    // Configuration registers.
    logic [LEN_W-1:0]  r_level_len;
    logic [LEN_W-1:0]  r_duty_len;
    logic [DATA_W-1:0] r_max_duty;

    // Sequencer state.
    t_state            r_state;
    logic              r_stage;
    logic [AW-1:0]     r_idx;
    logic [DATA_W-1:0] r_x;
    logic              r_err;
    logic [DATA_W-1:0] r_prev_key;
    logic [DATA_W-1:0] r_prev_val;

    // Interpolation datapath.
    logic              r_neg;
    logic [DATA_W-1:0] r_mag;
    logic [DATA_W-1:0] r_dx;
    logic [DATA_W-1:0] r_dk;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [IDX_W-1:0]  r_cnt;

    // Output register.
    logic              r_out_valid;
    logic [DATA_W-1:0] r_duty;
    logic              r_table_error;

    logic              in_accept;
    logic              out_free;
    logic              write_ok;
    logic [LW-1:0]     level_n;
    logic [LW-1:0]     duty_n;
    logic [LW-1:0]     cur_n;
    logic              short_table;
    logic [EW-1:0]     rd_word;
    logic [DATA_W-1:0] rd_key;
    logic [DATA_W-1:0] rd_val;
    logic              at_last;
    logic              fin;
    logic [DATA_W-1:0] fin_val;
    logic [DATA_W-1:0] interp;
    logic [EW-1:0]     product;
    logic [DATA_W:0]   div_trial;
    logic              div_ge;
    logic [DATA_W-1:0] div_rem;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign write_ok  = 32'(i_entry_index) < TABLE_DEPTH;

    // Length registers above the depth saturate to the depth.
    assign level_n = (r_level_len > TABLE_DEPTH) ? LW'(TABLE_DEPTH) : LW'(r_level_len);
    assign duty_n  = (r_duty_len > TABLE_DEPTH) ? LW'(TABLE_DEPTH) : LW'(r_duty_len);
    assign cur_n   = r_stage ? duty_n : level_n;
    assign short_table = (level_n < LW'(2)) || (duty_n < LW'(2));

    // Table memories: one write port fed by the write commands, and one read
    // port each, always addressed by the walk index.
    always_ff @(posedge i_clk) begin
        if (in_accept && write_ok && (t_command'(i_command) == CMD_WRITE_LEVEL)) begin
            level_mem[AW'(i_entry_index)] <= {i_entry_key, i_entry_value};
        end
        r_level_rd <= level_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && write_ok && (t_command'(i_command) == CMD_WRITE_DUTY)) begin
            duty_mem[AW'(i_entry_index)] <= {i_entry_key, i_entry_value};
        end
        r_duty_rd <= duty_mem[r_idx];
    end

    assign rd_word = r_stage ? r_duty_rd : r_level_rd;
    assign rd_key  = rd_word[EW-1:DATA_W];
    assign rd_val  = rd_word[DATA_W-1:0];
    assign at_last = (LW'(r_idx) == (cur_n - LW'(1)));

    // The interpolated value lies between the two neighbouring table values,
    // so the 16-bit add or subtract cannot leave the range.
    assign interp  = r_neg ? (r_prev_val - r_quo) : (r_prev_val + r_quo);
    assign product = EW'(r_mag) * EW'(r_dx);

    // One step of restoring division. The remainder always stays below the
    // divisor, so it needs only sixteen bits.
    assign div_trial = {r_rem, r_quo[DATA_W-1]};
    assign div_ge    = div_trial >= {1'b0, r_dk};
    assign div_rem   = div_ge ? DATA_W'(div_trial - {1'b0, r_dk}) : div_trial[DATA_W-1:0];

    // A lookup ends on an exact match, on a key below the first entry, after
    // the last entry, or once an interpolation has been summed.
    always_comb begin
        fin     = 1'b0;
        fin_val = rd_val;
        case (r_state)
            S_CMP: begin
                if ((r_x == rd_key) || ((r_x < rd_key) && (r_idx == '0))
                        || ((r_x > rd_key) && at_last)) begin
                    fin = 1'b1;
                end
            end
            S_ADD: begin
                fin     = 1'b1;
                fin_val = interp;
            end
            default: begin
                fin = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_stage       <= 1'b0;
            r_idx         <= '0;
            r_out_valid   <= 1'b0;
            r_level_len   <= '0;
            r_duty_len    <= '0;
            r_max_duty    <= MAX_DUTY_RESET;
            r_err         <= 1'b0;
            r_cnt         <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_index))
                    REG_LEVEL_LEN: r_level_len <= i_cfg_data[LEN_W-1:0];
                    REG_DUTY_LEN:  r_duty_len  <= i_cfg_data[LEN_W-1:0];
                    REG_MAX_DUTY:  r_max_duty  <= i_cfg_data;
                    default:       r_max_duty  <= r_max_duty;
                endcase
            end

            // A result leaves unless the sequencer loads the next one this cycle.
            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_accept && (t_command'(i_command) == CMD_CONVERT)) begin
                        r_stage <= 1'b0;
                        r_idx   <= '0;
                        r_err   <= short_table;
                        r_x     <= (short_table || (i_level == '0)) ? '0 : i_level;
                        if (short_table || (i_level == '0)) begin
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_WAIT;
                        end
                    end
                end
                S_WAIT: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (!fin) begin
                        if (r_x < rd_key) begin
                            // The previous key is below the search value here, so
                            // the key step is positive and so is the offset.
                            r_neg   <= rd_val < r_prev_val;
                            r_mag   <= (rd_val < r_prev_val) ? (r_prev_val - rd_val)
                                                             : (rd_val - r_prev_val);
                            r_dx    <= r_x - r_prev_key;
                            r_dk    <= rd_key - r_prev_key;
                            r_state <= S_MUL;
                        end else begin
                            r_prev_key <= rd_key;
                            r_prev_val <= rd_val;
                            r_idx      <= r_idx + AW'(1);
                            r_state    <= S_WAIT;
                        end
                    end
                end
                S_MUL: begin
                    r_rem   <= product[EW-1:DATA_W];
                    r_quo   <= product[DATA_W-1:0];
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= div_rem;
                    r_quo <= {r_quo[DATA_W-2:0], div_ge};
                    r_cnt <= r_cnt + IDX_W'(1);
                    if (r_cnt == '1) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    // The lookup is closed below.
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        r_duty        <= r_x;
                        r_table_error <= r_err;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // Close a lookup: the brightness feeds the second walk, and the
            // second walk's value is capped and sent to the output.
            if (fin) begin
                if (!r_stage) begin
                    r_x     <= fin_val;
                    r_stage <= 1'b1;
                    r_idx   <= '0;
                    r_state <= S_WAIT;
                end else begin
                    r_x     <= (fin_val > r_max_duty) ? r_max_duty : fin_val;
                    r_state <= S_OUT;
                end
            end
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_duty        = r_duty;
    assign o_table_error = r_table_error;

`ifndef NO_ASSERTIONS
    a_duty_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_x <= r_max_duty))
        else $error("duty above the configured cap");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_table_error) |-> (o_duty == '0))
        else $error("table error with a non-zero duty");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_dk))
        else $error("divider remainder not below divisor");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (LW'(r_idx) < cur_n))
        else $error("table walk beyond the valid length");

    a_short_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (t_command'(i_command) == CMD_CONVERT) && short_table)
        |=> (r_state == S_OUT) && r_err)
        else $error("short table did not flag an error");
`endif

endmodule

// ===== sim/tspl_checker.sv =====
// Checker for the two-stage piecewise-linear map: watches the configuration port and both
// transaction channels, predicts each conversion result and compares it field by field.
// Depends on tspl_pkg; instantiated by tb beside the block.
`timescale 1ns / 1ps

module tspl_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [tspl_pkg::CMD_W-1:0]    i_command,
    input  logic [tspl_pkg::IDX_W-1:0]    i_entry_index,
    input  logic [tspl_pkg::DATA_W-1:0]   i_entry_key,
    input  logic [tspl_pkg::DATA_W-1:0]   i_entry_value,
    input  logic [tspl_pkg::DATA_W-1:0]   i_level,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [tspl_pkg::DATA_W-1:0]   i_duty,
    input  logic                          i_table_error,
    input  logic                          i_cfg_we,
    input  logic [tspl_pkg::CFG_A_W-1:0]  i_cfg_index,
    input  logic [tspl_pkg::DATA_W-1:0]   i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);
    import tspl_pkg::*;

    localparam int DEPTH = 16;

    typedef struct packed {
        logic [DATA_W-1:0] duty;
        logic              table_error;
    } t_duty_result;

    logic [DATA_W-1:0] lvl_keys   [DEPTH];
    logic [DATA_W-1:0] lvl_bright [DEPTH];
    logic [DATA_W-1:0] brt_keys   [DEPTH];
    logic [DATA_W-1:0] brt_duty   [DEPTH];
    logic [LEN_W-1:0]  lvl_len;
    logic [LEN_W-1:0]  brt_len;
    logic [DATA_W-1:0] duty_cap;

    t_duty_result duty_expected_q[$];
    int           mismatch_total;

    // One table walk: exact match, clamp at either end, or a linear step between
    // neighbours with the division truncated toward zero.
    function automatic logic [DATA_W-1:0] walk_table(input bit use_duty_table,
                                                     input int unsigned n,
                                                     input int unsigned x);
        logic [DATA_W-1:0] k, kp, v, vp;
        longint            vcur, vprev, kcur, kprev, xs, r;
        for (int i = 0; i < n; i++) begin
            k = use_duty_table ? brt_keys[i] : lvl_keys[i];
            v = use_duty_table ? brt_duty[i] : lvl_bright[i];
            if (x == k)
                return v;
            if (x < k) begin
                if (i == 0)
                    return v;
                kp    = use_duty_table ? brt_keys[i-1] : lvl_keys[i-1];
                vp    = use_duty_table ? brt_duty[i-1] : lvl_bright[i-1];
                vcur  = v;
                vprev = vp;
                kcur  = k;
                kprev = kp;
                xs    = x;
                if (kcur - kprev <= 0)
                    return vp;
                r = vprev + ((vcur - vprev) * (xs - kprev)) / (kcur - kprev);
                if (r < 0)
                    r = 0;
                if (r > 65535)
                    r = 65535;
                return r[DATA_W-1:0];
            end
        end
        return use_duty_table ? brt_duty[n-1] : lvl_bright[n-1];
    endfunction

    function automatic t_duty_result map_level_to_duty(input logic [DATA_W-1:0] lvl);
        t_duty_result      res;
        int unsigned       nl, nd;
        logic [DATA_W-1:0] bright, duty;
        nl  = (lvl_len > DEPTH) ? DEPTH : lvl_len;
        nd  = (brt_len > DEPTH) ? DEPTH : brt_len;
        res = '0;
        if (nl < 2 || nd < 2) begin
            res.table_error = 1'b1;
        end else if (lvl != 0) begin
            bright = walk_table(1'b0, nl, lvl);
            duty   = walk_table(1'b1, nd, bright);
            res.duty = (duty > duty_cap) ? duty_cap : duty;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_duty_result seen, want;
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                lvl_keys[i]   = '0;
                lvl_bright[i] = '0;
                brt_keys[i]   = '0;
                brt_duty[i]   = '0;
            end
            lvl_len  = '0;
            brt_len  = '0;
            duty_cap = MAX_DUTY_RESET;
            duty_expected_q.delete();
            mismatch_total = 0;
        end else begin
            // Results are taken first: a conversion never answers in the cycle it is accepted.
            if (i_out_valid && !i_out_stall) begin
                seen.duty        = i_duty;
                seen.table_error = i_table_error;
                if (duty_expected_q.size() == 0) begin
                    if (mismatch_total < 10)
                        $display("[%0t] unexpected result: duty %0d table_error %0b",
                                 $realtime, seen.duty, seen.table_error);
                    mismatch_total++;
                end else begin
                    want = duty_expected_q.pop_front();
                    if (seen.duty !== want.duty || seen.table_error !== want.table_error) begin
                        if (mismatch_total < 10)
                            $display("[%0t] mismatch: duty %0d (expected %0d), %s %0b (%0b)",
                                     $realtime, seen.duty, want.duty, "table_error",
                                     seen.table_error, want.table_error);
                        mismatch_total++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_index))
                    REG_LEVEL_LEN: lvl_len  = i_cfg_data[LEN_W-1:0];
                    REG_DUTY_LEN:  brt_len  = i_cfg_data[LEN_W-1:0];
                    REG_MAX_DUTY:  duty_cap = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                case (t_command'(i_command))
                    CMD_CONVERT: duty_expected_q.push_back(map_level_to_duty(i_level));
                    CMD_WRITE_LEVEL: begin
                        lvl_keys[i_entry_index]   = i_entry_key;
                        lvl_bright[i_entry_index] = i_entry_value;
                    end
                    CMD_WRITE_DUTY: begin
                        brt_keys[i_entry_index] = i_entry_key;
                        brt_duty[i_entry_index] = i_entry_value;
                    end
                    default: ;
                endcase
            end
        end
        o_pending    <= duty_expected_q.size();
        o_fail_count <= mismatch_total;
    end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the two-stage piecewise-linear map: clock, reset, configuration,
// stimulus and the final verdict. Depends on tspl_pkg, two_stage_piecewise_linear_map
// and tspl_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module tb;
    import tspl_pkg::*;

    localparam int DEPTH        = 16;
    // Long enough for any work still in flight to finish.
    localparam int DRAIN_CYCLES = 150;
    // The limit lies far above the length of the slowest correct run.
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int TOTAL_ITEMS  = 1150;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [CMD_W-1:0]    i_command;
    logic [IDX_W-1:0]    i_entry_index;
    logic [DATA_W-1:0]   i_entry_key;
    logic [DATA_W-1:0]   i_entry_value;
    logic [DATA_W-1:0]   i_level;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [DATA_W-1:0]   o_duty;
    logic                o_table_error;
    logic                i_cfg_we;
    logic [CFG_A_W-1:0]  i_cfg_index;
    logic [DATA_W-1:0]   i_cfg_data;

    int fail_count;
    int pending;
    int cycle_count    = 0;
    int item_count     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int phase          = 0;

    // Copies of the keys written so far, kept only to steer levels onto and around them
    // and to build level tables whose brightness values land exactly on duty keys.
    logic [DATA_W-1:0] lvl_key_shadow  [DEPTH];
    logic [DATA_W-1:0] duty_key_shadow [DEPTH];

    two_stage_piecewise_linear_map DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_entry_index (i_entry_index),
        .i_entry_key   (i_entry_key),
        .i_entry_value (i_entry_value),
        .i_level       (i_level),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_duty        (o_duty),
        .o_table_error (o_table_error),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    tspl_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_entry_index (i_entry_index),
        .i_entry_key   (i_entry_key),
        .i_entry_value (i_entry_value),
        .i_level       (i_level),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_duty        (o_duty),
        .i_table_error (o_table_error),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Receiver back-pressure: a fresh draw every cycle at the current stall rate.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Watchdog: a hung handshake ends the run here rather than hanging the simulator.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Offers one input transaction and returns at the edge where it is accepted. The
    // sender may idle first; valid is lowered only for those idle cycles, so back-to-back
    // transactions keep it high without a second assignment in the same time step.
    task automatic send_item(input t_command cmd, input logic [IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] key, input logic [DATA_W-1:0] val,
                             input logic [DATA_W-1:0] lvl);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_entry_index <= idx;
        i_entry_key   <= key;
        i_entry_value <= val;
        i_level       <= lvl;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        item_count++;
    endtask

    // Fields that a conversion ignores are still randomised, so that every bit toggles.
    task automatic convert(input logic [DATA_W-1:0] lvl);
        send_item(CMD_CONVERT, IDX_W'($urandom), DATA_W'($urandom), DATA_W'($urandom), lvl);
    endtask

    task automatic write_entry(input t_command cmd, input logic [IDX_W-1:0] idx,
                               input logic [DATA_W-1:0] key, input logic [DATA_W-1:0] val);
        send_item(cmd, idx, key, val, DATA_W'($urandom));
        if (cmd == CMD_WRITE_LEVEL)
            lvl_key_shadow[idx] = key;
        else
            duty_key_shadow[idx] = key;
    endtask

    // Rewrites a whole table with ascending keys. The spacing varies from tight to wide,
    // steps of zero give repeated keys, and the top key sometimes sits at the very end of
    // the range. Half of the level table's brightness values are taken from duty keys so
    // that the second lookup also hits exact matches.
    task automatic load_sorted_table(input t_command cmd);
        int unsigned       k, step_max;
        logic [DATA_W-1:0] key, val;
        case ($urandom_range(0, 2))
            0:       step_max = 300;
            1:       step_max = 4096;
            default: step_max = 9000;
        endcase
        k = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 2000);
        for (int i = 0; i < DEPTH; i++) begin
            key = (k > 65535) ? 16'hFFFF : k[DATA_W-1:0];
            if (i == DEPTH - 1 && $urandom_range(0, 3) == 0)
                key = 16'hFFFF;
            if (cmd == CMD_WRITE_LEVEL && $urandom_range(0, 1) == 1)
                val = duty_key_shadow[$urandom_range(0, DEPTH - 1)];
            else
                val = DATA_W'($urandom);
            write_entry(cmd, IDX_W'(i), key, val);
            k = k + $urandom_range(0, step_max);
        end
    endtask

    // Changes one entry. Most keep the old key so the table stays in order; the rest
    // put a random key in and so exercise a walk over unsorted keys.
    task automatic tweak_entry(input t_command cmd);
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] key;
        idx = IDX_W'($urandom_range(0, DEPTH - 1));
        if ($urandom_range(0, 3) == 0)
            key = DATA_W'($urandom);
        else
            key = (cmd == CMD_WRITE_LEVEL) ? lvl_key_shadow[idx] : duty_key_shadow[idx];
        write_entry(cmd, idx, key, DATA_W'($urandom));
    endtask

    // Levels are aimed at zero, the top of the range, exact keys and their neighbours,
    // with plain random levels for the rest.
    function automatic logic [DATA_W-1:0] pick_level();
        logic [DATA_W-1:0] base;
        base = lvl_key_shadow[$urandom_range(0, DEPTH - 1)];
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 16'hFFFF;
            2, 3:    return base;
            4:       return base + 16'd1;
            5:       return base - 16'd1;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    // The three length and cap registers are written back to back on consecutive edges;
    // the write enable is lowered only after the last of them.
    task automatic set_config(input logic [LEN_W-1:0] level_len,
                              input logic [LEN_W-1:0] duty_len,
                              input logic [DATA_W-1:0] cap);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_LEVEL_LEN;
        i_cfg_data  <= {{(DATA_W-LEN_W){1'b0}}, level_len};
        @(posedge i_clk);
        i_cfg_index <= REG_DUTY_LEN;
        i_cfg_data  <= {{(DATA_W-LEN_W){1'b0}}, duty_len};
        @(posedge i_clk);
        i_cfg_index <= REG_MAX_DUTY;
        i_cfg_data  <= cap;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // The sender holds off until every expected result has come back, then lets a
    // table write or an ignored command still in flight settle before anything else.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [LEN_W-1:0] pick_length();
        case ($urandom_range(0, 9))
            0:       return LEN_W'($urandom_range(0, 1));
            1:       return LEN_W'($urandom_range(17, 31));
            2:       return LEN_W'(DEPTH);
            default: return LEN_W'($urandom_range(2, DEPTH));
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_cap();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 16'hFFFF;
            2:       return MAX_DUTY_RESET;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        int unsigned n_items, sel;
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_command     <= CMD_NONE;
        i_entry_index <= '0;
        i_entry_key   <= '0;
        i_entry_value <= '0;
        i_level       <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= REG_LEVEL_LEN;
        i_cfg_data    <= '0;
        for (int i = 0; i < DEPTH; i++) begin
            lvl_key_shadow[i]  = '0;
            duty_key_shadow[i] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Both lengths are zero after reset, so conversions report a
        // short table whatever the level, even a level of zero; the unused command
        // must produce nothing.
        send_idle_pct  = 9;
        recv_stall_pct = 75;
        convert(16'd0);
        convert(16'hFFFF);
        send_item(CMD_NONE, IDX_W'($urandom), DATA_W'($urandom), DATA_W'($urandom),
                  DATA_W'($urandom));

        // A small level table with a falling segment (negative slope) and a duty table
        // whose last key is the top of the range.
        write_entry(CMD_WRITE_LEVEL, 4'd0, 16'd10,    16'hFFFF);
        write_entry(CMD_WRITE_LEVEL, 4'd1, 16'd100,   16'd0);
        write_entry(CMD_WRITE_LEVEL, 4'd2, 16'd1000,  16'd30000);
        write_entry(CMD_WRITE_LEVEL, 4'd3, 16'd40000, 16'hFFFF);
        write_entry(CMD_WRITE_DUTY,  4'd0, 16'd0,     16'd0);
        write_entry(CMD_WRITE_DUTY,  4'd1, 16'd500,   16'hFFFF);
        write_entry(CMD_WRITE_DUTY,  4'd2, 16'd30000, 16'd100);
        write_entry(CMD_WRITE_DUTY,  4'd3, 16'hFFFF,  16'hFFFF);
        wait_idle();

        // The unused register index must be ignored.
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_UNUSED;
        i_cfg_data  <= 16'hA5C3;
        @(posedge i_clk);
        set_config(5'd4, 5'd4, 16'hFFFF);

        // Zero level, below the first key, exact keys, interpolation on both slopes,
        // above the last key and the top of the range.
        convert(16'd0);
        convert(16'd5);
        convert(16'd10);
        convert(16'd55);
        convert(16'd100);
        convert(16'd1000);
        convert(16'd20000);
        convert(16'd50000);
        convert(16'hFFFF);
        wait_idle();

        // A one-entry level table counts as short; then the cap cuts a full-scale duty.
        set_config(5'd1, 5'd4, 16'd1000);
        convert(16'd300);
        wait_idle();
        set_config(5'd4, 5'd4, 16'd1000);
        convert(16'd5);

        // Random part, in phases. Each phase starts from an idle block, writes the
        // registers, sometimes reloads a table in order and then runs a mix of
        // conversions, single-entry writes and ignored commands. The first phase fills
        // both tables completely, so no entry is read before it has been written.
        while (item_count < TOTAL_ITEMS) begin
            if (item_count < TOTAL_ITEMS / 3) begin
                send_idle_pct  = 9;
                recv_stall_pct = 75;
            end else if (item_count < 2 * TOTAL_ITEMS / 3) begin
                send_idle_pct  = 75;
                recv_stall_pct = 9;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            wait_idle();
            if (phase == 0)
                set_config(5'd31, 5'd31, 16'hFFFF);
            else if (phase == 1)
                set_config(LEN_W'(DEPTH), 5'd2, 16'd0);
            else
                set_config(pick_length(), pick_length(), pick_cap());

            if (phase == 0) begin
                load_sorted_table(CMD_WRITE_DUTY);
                load_sorted_table(CMD_WRITE_LEVEL);
            end else if ($urandom_range(0, 3) == 0) begin
                load_sorted_table($urandom_range(0, 1) ? CMD_WRITE_LEVEL : CMD_WRITE_DUTY);
            end

            n_items = $urandom_range(30, 60);
            for (int unsigned i = 0; i < n_items; i++) begin
                sel = $urandom_range(0, 99);
                if (sel < 70)
                    convert(pick_level());
                else if (sel < 82)
                    tweak_entry(CMD_WRITE_LEVEL);
                else if (sel < 94)
                    tweak_entry(CMD_WRITE_DUTY);
                else
                    send_item(CMD_NONE, IDX_W'($urandom), DATA_W'($urandom),
                              DATA_W'($urandom), DATA_W'($urandom));
            end
            phase++;
        end

        // Let every outstanding result drain, then give the verdict.
        recv_stall_pct = 0;
        wait_idle();
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== two_stage_piecewise_linear_map.f =====
hw/rtl/tspl_pkg.sv
hw/rtl/two_stage_piecewise_linear_map.sv
sim/tspl_checker.sv
sim/tb.sv
